[src/dls_pkg.sv]
package dls_pkg;

  // Scanner limits
  localparam int unsigned MaxDigits = 18;
  localparam int unsigned MaxExp    = 9999;

  // Field and state widths
  localparam int unsigned ChW     = 8;
  localparam int unsigned SigW    = 60;
  localparam int unsigned DecExpW = 16;
  localparam int unsigned CntW    = 16;
  localparam int unsigned KeptW   = 5;
  localparam int unsigned ExpValW = 14;
  localparam int unsigned AccW    = (MaxDigits > 18) ? 64 : 60;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 104;

  // Character codes
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChDot   = 8'h2E;
  localparam logic [ChW-1:0] ChLowE  = 8'h65;
  localparam logic [ChW-1:0] ChUpE   = 8'h45;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;

  // One input character beat
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } in_beat_t;

  // One scan result, ok in the lowest bit
  typedef struct packed {
    logic                      truncated;
    logic [ChW-1:0]            terminator;
    logic                      has_terminator;
    logic [CntW-1:0]           consumed;
    logic signed [DecExpW-1:0] dec_exponent;
    logic [SigW-1:0]           significand;
    logic                      ok;
  } scan_res_t;

endpackage

[src/dls_in_stage.sv]
module dls_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  dls_pkg::in_beat_t s_beat_i,
  output logic              beat_valid_o,
  output dls_pkg::in_beat_t beat_o,
  input  logic              take_i
);

  logic              vld_q;
  dls_pkg::in_beat_t beat_q;

  // Accept a new beat when empty or when the held beat is taken this cycle
  assign s_ready_o = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      beat_q <= s_beat_i;
    end
  end

  assign beat_valid_o = vld_q;
  assign beat_o       = beat_q;

endmodule

[src/dls_scan.sv]
module dls_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_valid_i,
  input  dls_pkg::in_beat_t  beat_i,
  input  logic               fire_i,
  output logic               res_valid_o,
  output dls_pkg::scan_res_t res_o
);

  typedef enum logic [2:0] {
    PhInt,
    PhFrac,
    PhEmark,
    PhEsign,
    PhEdig
  } phase_e;

  localparam int unsigned EvW  = dls_pkg::ExpValW + 4;
  localparam int unsigned ESumW = dls_pkg::DecExpW + 2;
  localparam logic signed [dls_pkg::DecExpW-1:0] ScaleMax = 16'sh7FFF;
  localparam logic signed [dls_pkg::DecExpW-1:0] ScaleMin = 16'sh8000;
  localparam logic signed [ESumW-1:0] ESatMax = 18'sh07FFF;
  localparam logic signed [ESumW-1:0] ESatMin = -18'sh08000;

  phase_e                             phase_q, phase_d;
  logic [dls_pkg::AccW-1:0]           acc_q, acc_d;
  logic [dls_pkg::KeptW-1:0]          kept_q, kept_d;
  logic signed [dls_pkg::DecExpW-1:0] scale_q, scale_d;
  logic [dls_pkg::ExpValW-1:0]        expv_q, expv_d;
  logic                               expneg_q, expneg_d;
  logic [dls_pkg::CntW-1:0]           cnt_q, cnt_d;
  logic                               lost_q, lost_d;

  // Values after this character, before any clear
  phase_e                             phase_t;
  logic [dls_pkg::AccW-1:0]           acc_t;
  logic [dls_pkg::KeptW-1:0]          kept_t;
  logic signed [dls_pkg::DecExpW-1:0] scale_t;
  logic [dls_pkg::ExpValW-1:0]        expv_t;
  logic                               expneg_t;
  logic [dls_pkg::CntW-1:0]           cnt_t;
  logic                               lost_t;

  logic                       is_digit;
  logic [3:0]                 dig;
  logic                       take;
  logic                       emit;
  logic                       frac;
  logic                       sc_inc, sc_dec;
  logic [dls_pkg::AccW+3:0]   acc_mul;
  logic [EvW-1:0]             ev;
  logic signed [ESumW-1:0]    e_sum;
  logic signed [ESumW-1:0]    e_exp;
  logic                       e_sat_hi, e_sat_lo;
  logic                       ok;
  logic                       lost_e;

  assign is_digit = (beat_i.ch >= dls_pkg::ChZero) && (beat_i.ch <= dls_pkg::ChNine);
  assign dig      = beat_i.ch[3:0];
  assign frac     = (phase_q == PhFrac);

  // Times ten plus digit by shift and add
  assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {{dls_pkg::AccW{1'b0}}, dig};
  assign ev      = {1'b0, expv_q, 3'b000} + {3'b000, expv_q, 1'b0}
                 + {{(EvW-4){1'b0}}, dig};

  // Step the scan state by one character
  always_comb begin
    phase_t  = phase_q;
    acc_t    = acc_q;
    kept_t   = kept_q;
    expv_t   = expv_q;
    expneg_t = expneg_q;
    lost_t   = lost_q;
    sc_inc   = 1'b0;
    sc_dec   = 1'b0;
    take     = 1'b1;
    if (is_digit) begin
      if (phase_q == PhInt || phase_q == PhFrac) begin
        if (acc_q == '0 && dig == 4'd0) begin
          sc_dec = frac;
        end else if (kept_q < dls_pkg::KeptW'(dls_pkg::MaxDigits)) begin
          acc_t  = acc_mul[dls_pkg::AccW-1:0];
          kept_t = kept_q + 1'b1;
          sc_dec = frac;
        end else begin
          lost_t = 1'b1;
          sc_inc = !frac;
        end
      end else begin
        if (ev > EvW'(dls_pkg::MaxExp)) begin
          expv_t = dls_pkg::ExpValW'(dls_pkg::MaxExp);
          lost_t = 1'b1;
        end else begin
          expv_t = ev[dls_pkg::ExpValW-1:0];
        end
        phase_t = PhEdig;
      end
    end else if (beat_i.ch == dls_pkg::ChDot) begin
      if (phase_q == PhInt) begin
        phase_t = PhFrac;
      end else begin
        take = 1'b0;
      end
    end else if (beat_i.ch == dls_pkg::ChLowE || beat_i.ch == dls_pkg::ChUpE) begin
      if (phase_q == PhInt || phase_q == PhFrac) begin
        phase_t = PhEmark;
      end else begin
        take = 1'b0;
      end
    end else if ((beat_i.ch == dls_pkg::ChMinus || beat_i.ch == dls_pkg::ChPlus)
                 && phase_q == PhEmark) begin
      expneg_t = (beat_i.ch == dls_pkg::ChMinus);
      phase_t  = PhEsign;
    end else begin
      take = 1'b0;
    end
  end

  // Saturating scale step
  always_comb begin
    scale_t = scale_q;
    if (sc_inc && scale_q != ScaleMax) begin
      scale_t = scale_q + 16'sd1;
    end else if (sc_dec && scale_q != ScaleMin) begin
      scale_t = scale_q - 16'sd1;
    end
  end

  // Saturating character count
  assign cnt_t = (take && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign emit  = !take || beat_i.last;

  // Final exponent with saturation
  assign e_exp    = expneg_t ? -$signed({4'b0000, expv_t}) : $signed({4'b0000, expv_t});
  assign e_sum    = ESumW'(scale_t) + e_exp;
  assign e_sat_hi = (e_sum > ESatMax);
  assign e_sat_lo = (e_sum < ESatMin);
  assign lost_e   = lost_t || e_sat_hi || e_sat_lo;
  assign ok       = (cnt_t != '0) && (phase_t != PhEmark) && (phase_t != PhEsign);

  // Format the result
  always_comb begin
    res_o.ok             = ok;
    res_o.significand    = ok ? acc_t[dls_pkg::SigW-1:0] : '0;
    if (!ok) begin
      res_o.dec_exponent = '0;
    end else if (e_sat_hi) begin
      res_o.dec_exponent = ScaleMax;
    end else if (e_sat_lo) begin
      res_o.dec_exponent = ScaleMin;
    end else begin
      res_o.dec_exponent = e_sum[dls_pkg::DecExpW-1:0];
    end
    res_o.consumed       = cnt_t;
    res_o.has_terminator = !take;
    res_o.terminator     = take ? '0 : beat_i.ch;
    res_o.truncated      = ok && lost_e;
  end

  assign res_valid_o = beat_valid_i && emit;

  // Clear after a result, otherwise carry the stepped state
  always_comb begin
    if (emit) begin
      phase_d  = PhInt;
      acc_d    = '0;
      kept_d   = '0;
      scale_d  = '0;
      expv_d   = '0;
      expneg_d = 1'b0;
      cnt_d    = '0;
      lost_d   = 1'b0;
    end else begin
      phase_d  = phase_t;
      acc_d    = acc_t;
      kept_d   = kept_t;
      scale_d  = scale_t;
      expv_d   = expv_t;
      expneg_d = expneg_t;
      cnt_d    = cnt_t;
      lost_d   = lost_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhInt;
      acc_q    <= '0;
      kept_q   <= '0;
      scale_q  <= '0;
      expv_q   <= '0;
      expneg_q <= 1'b0;
      cnt_q    <= '0;
      lost_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      kept_q   <= kept_d;
      scale_q  <= scale_d;
      expv_q   <= expv_d;
      expneg_q <= expneg_d;
      cnt_q    <= cnt_d;
      lost_q   <= lost_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o |=> phase_q == PhInt && cnt_q == '0 && acc_q == '0)
    else $error("scan state not cleared after result");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && beat_valid_i && !res_valid_o |=> cnt_q != '0)
    else $error("consumed character not counted");

  a_invalid_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.ok |->
      res_o.significand == '0 && res_o.dec_exponent == '0 && !res_o.truncated)
    else $error("invalid literal carries value");

  a_end_without_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.has_terminator |-> beat_i.last)
    else $error("result without terminator before end of text");
`endif

endmodule

[src/dls_out_stage.sv]
module dls_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  dls_pkg::scan_res_t res_i,
  output logic               space_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output dls_pkg::scan_res_t m_res_o
);

  logic               vld_q;
  dls_pkg::scan_res_t res_q;

  // Room when empty or when the held beat leaves this cycle
  assign space_o = !vld_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (space_o) begin
      vld_q <= res_valid_i;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = vld_q;
  assign m_res_o   = res_q;

endmodule

[src/decimal_literal_scanner.sv]
// Throughput: one character per cycle while the output register has room; the state
// step is a times-ten shift-add of the significand and a saturating exponent add
// between the input and result registers. A result waiting in the output register
// does not stop intake until the input register is also full. Reset (rst_ni low,
// asynchronous) empties both registers and returns the scan to the start of a literal.
module decimal_literal_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dls_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] ch
  input  logic                         s_axis_tlast,  // last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] ok, [60:1] significand, [76:61] dec_exponent, [92:77] consumed,
  // [93] has_terminator, [101:94] terminator, [102] truncated, [103] zero
  output logic [dls_pkg::OutDataW-1:0] m_axis_tdata
);

  dls_pkg::in_beat_t  s_beat;
  dls_pkg::in_beat_t  beat;
  dls_pkg::scan_res_t res;
  dls_pkg::scan_res_t m_res;
  logic               beat_valid;
  logic               res_valid;
  logic               space;
  logic               take;

  assign s_beat.ch   = s_axis_tdata[dls_pkg::ChW-1:0];
  assign s_beat.last = s_axis_tlast;

  // Step a held character once the result register has room
  assign take = beat_valid && space;

  dls_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_beat_i     (s_beat),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .take_i       (take)
  );

  dls_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_i       (beat),
    .fire_i       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  dls_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata = {1'b0, m_res};

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomChars = 1000;
  localparam int unsigned QuietChars  = 300;
  localparam int unsigned DrainCycles = 8;

  // Scan phases of the literal being assembled
  typedef enum logic [2:0] {
    PhInt,
    PhFrac,
    PhMark,
    PhSign,
    PhExpDig
  } scan_phase_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dls_pkg::InDataW-1:0]  s_axis_tdata = '0;  // [7:0] ch
  logic                         s_axis_tlast = 1'b0;  // last
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [0] ok, [60:1] significand, [76:61] dec_exponent, [92:77] consumed,
  // [93] has_terminator, [101:94] terminator, [102] truncated, [103] zero
  logic [dls_pkg::OutDataW-1:0] m_axis_tdata;

  decimal_literal_scanner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Scanner state mirrored by the predictor
  scan_phase_e ph = PhInt;
  logic [63:0] sig_acc = '0;
  int unsigned kept = 0;
  int          scale = 0;
  int unsigned exp_val = 0;
  bit          exp_neg = 1'b0;
  int unsigned char_cnt = 0;
  bit          lost = 1'b0;

  dls_pkg::scan_res_t literal_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned sink_burst = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic void clear_scan();
    ph = PhInt;
    sig_acc = '0;
    kept = 0;
    scale = 0;
    exp_val = 0;
    exp_neg = 1'b0;
    char_cnt = 0;
    lost = 1'b0;
  endfunction

  // Saturate the scale adjustment to 16 signed bits
  function automatic void bump_scale(int d);
    int s;
    s = scale + d;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    scale = s;
  endfunction

  function automatic void mantissa_digit(int unsigned dig, bit frac);
    if (sig_acc == 0 && dig == 0) begin
      // leading zero: not kept, but still shifts the point in the fraction
      if (frac) bump_scale(-1);
    end else if (kept < dls_pkg::MaxDigits) begin
      sig_acc = sig_acc * 10 + dig;
      kept++;
      if (frac) bump_scale(-1);
    end else begin
      // drop the digit; an integer digit still scales the value up
      lost = 1'b1;
      if (!frac) bump_scale(1);
    end
  endfunction

  function automatic void exponent_digit(int unsigned dig);
    int unsigned v;
    v = exp_val * 10 + dig;
    if (v > dls_pkg::MaxExp) begin
      v = dls_pkg::MaxExp;
      lost = 1'b1;
    end
    exp_val = v;
  endfunction

  function automatic dls_pkg::scan_res_t close_literal(bit term, logic [7:0] c);
    dls_pkg::scan_res_t r;
    bit ok;
    bit trunc;
    int e;
    ok = char_cnt > 0 && ph != PhMark && ph != PhSign;
    e = scale + (exp_neg ? -int'(exp_val) : int'(exp_val));
    trunc = lost;
    if (e > 32767) begin
      e = 32767;
      trunc = 1'b1;
    end
    if (e < -32768) begin
      e = -32768;
      trunc = 1'b1;
    end
    r = '0;
    r.ok = ok;
    r.significand = ok ? sig_acc[dls_pkg::SigW-1:0] : '0;
    r.dec_exponent = ok ? e[dls_pkg::DecExpW-1:0] : '0;
    r.consumed = char_cnt[dls_pkg::CntW-1:0];
    r.has_terminator = term;
    r.terminator = term ? c : '0;
    r.truncated = ok && trunc;
    return r;
  endfunction

  // Advance the scan by one character; returns 1 when a literal closes
  function automatic bit scan_literal_char(logic [7:0] c, bit lst,
                                           output dls_pkg::scan_res_t r);
    bit take;
    int unsigned dig;
    take = 1'b1;
    r = '0;
    if (c >= dls_pkg::ChZero && c <= dls_pkg::ChNine) begin
      dig = int'(c - dls_pkg::ChZero);
      case (ph)
        PhInt:  mantissa_digit(dig, 1'b0);
        PhFrac: mantissa_digit(dig, 1'b1);
        default: begin
          exponent_digit(dig);
          ph = PhExpDig;
        end
      endcase
    end else if (c == dls_pkg::ChDot) begin
      if (ph == PhInt) ph = PhFrac;
      else take = 1'b0;
    end else if (c == dls_pkg::ChLowE || c == dls_pkg::ChUpE) begin
      if (ph == PhInt || ph == PhFrac) ph = PhMark;
      else take = 1'b0;
    end else if ((c == dls_pkg::ChMinus || c == dls_pkg::ChPlus) && ph == PhMark) begin
      exp_neg = (c == dls_pkg::ChMinus);
      ph = PhSign;
    end else begin
      take = 1'b0;
    end

    if (take) begin
      if (char_cnt < 65535) char_cnt++;
      if (!lst) return 1'b0;
      r = close_literal(1'b0, 8'h00);
    end else begin
      r = close_literal(1'b1, c);
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic void flag_error(string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endfunction

  function automatic void check_scan(dls_pkg::scan_res_t want, dls_pkg::scan_res_t got);
    bit bad;
    bad = (want.ok !== got.ok) || (want.significand !== got.significand) ||
          (want.dec_exponent !== got.dec_exponent) || (want.consumed !== got.consumed) ||
          (want.has_terminator !== got.has_terminator) ||
          (want.terminator !== got.terminator) || (want.truncated !== got.truncated);
    if (bad)
      flag_error($sformatf({"mismatch at cycle %0d (want/got): ok %0d/%0d sig %0d/%0d ",
                            "exp %0d/%0d consumed %0d/%0d term %0d:%h/%0d:%h trunc %0d/%0d"},
                           cycle_cnt, want.ok, got.ok, want.significand, got.significand,
                           want.dec_exponent, got.dec_exponent, want.consumed, got.consumed,
                           want.has_terminator, want.terminator, got.has_terminator,
                           got.terminator, want.truncated, got.truncated));
  endfunction

  // Check result beats and predict from accepted character beats
  always @(posedge clk_i) begin
    dls_pkg::scan_res_t got;
    dls_pkg::scan_res_t nxt;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = dls_pkg::scan_res_t'(m_axis_tdata[dls_pkg::OutDataW-2:0]);
        if (literal_q.size() == 0)
          flag_error($sformatf("result beat with nothing pending at cycle %0d", cycle_cnt));
        else
          check_scan(literal_q.pop_front(), got);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (scan_literal_char(s_axis_tdata[dls_pkg::ChW-1:0], s_axis_tlast, nxt))
          literal_q.push_back(nxt);
      end
    end
  end

  // Result side: long hold-off first, then random stall bursts
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready = 1'b0;
      sink_hold--;
    end else if (sink_burst > 0) begin
      m_axis_tready = 1'b0;
      sink_burst--;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready = 1'b0;
      sink_burst = $urandom_range(0, 5);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Offer one character beat; entered and left at a falling edge
  task automatic send_char(logic [7:0] c, bit lst);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = c;
    s_axis_tlast = lst;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    sent_cnt++;
  endtask

  task automatic send_text(string s, bit lst_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], lst_at_end && (i == s.len() - 1));
  endtask

  task automatic wait_results_drained();
    while (literal_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_digit();
    return dls_pkg::ChZero + 8'($urandom_range(0, 9));
  endfunction

  // Build one random literal, not always well-formed, ended by text end
  // or followed by one more character that may or may not terminate it
  task automatic send_random_literal();
    logic [7:0] lit[$];
    int unsigned n;
    int unsigned pick;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) lit.push_back(dls_pkg::ChZero);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
    repeat (n) lit.push_back(rand_digit());
    if ($urandom_range(0, 1)) begin
      lit.push_back(dls_pkg::ChDot);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) lit.push_back(dls_pkg::ChZero);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 4);
      repeat (n) lit.push_back(rand_digit());
    end
    if ($urandom_range(0, 1)) begin
      lit.push_back($urandom_range(0, 1) ? dls_pkg::ChLowE : dls_pkg::ChUpE);
      if ($urandom_range(0, 1))
        lit.push_back($urandom_range(0, 1) ? dls_pkg::ChMinus : dls_pkg::ChPlus);
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? 0 : (pick < 7) ? $urandom_range(1, 3) : $urandom_range(4, 6);
      repeat (n) lit.push_back(rand_digit());
    end
    if (lit.size() > 0 && $urandom_range(0, 1)) begin
      foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
    end else begin
      foreach (lit[i]) send_char(lit[i], 1'b0);
      case ($urandom_range(0, 7))
        0: send_char(" ", 1'($urandom_range(0, 1)));
        1: send_char(",", 1'($urandom_range(0, 1)));
        2: send_char(dls_pkg::ChDot, 1'($urandom_range(0, 1)));
        3: send_char(dls_pkg::ChLowE, 1'($urandom_range(0, 1)));
        4: send_char(dls_pkg::ChPlus, 1'($urandom_range(0, 1)));
        5: send_char(dls_pkg::ChMinus, 1'($urandom_range(0, 1)));
        6: send_char(dls_pkg::ChUpE, 1'($urandom_range(0, 1)));
        default: send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic send_random_mix(int unsigned count);
    int unsigned start;
    start = sent_cnt;
    while (sent_cnt - start < count) begin
      if ($urandom_range(0, 6) == 0)
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      else
        send_random_literal();
    end
  endtask

  // Marks alone, invalid endings, misplaced signs and extreme codes
  task automatic test_special_cases();
    send_text("0", 1'b1);
    send_text(".", 1'b1);
    send_text("e5", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("1e", 1'b1);
    send_text("1e+", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("1.5.", 1'b0);
    send_text("2e3e", 1'b0);
    send_text("9.E-7-", 1'b0);
    send_text("3e.", 1'b1);
  endtask

  // Drop surplus digits and saturate the exponent value
  task automatic test_long_literals();
    send_char("1", 1'b0);
    repeat (29) send_char("7", 1'b0);
    send_text("e99999", 1'b1);
    send_char(dls_pkg::ChDot, 1'b0);
    repeat (40) send_char(dls_pkg::ChZero, 1'b0);
    send_text("5e-99999", 1'b1);
    wait_results_drained();
  endtask

  // Hold the result side off long enough that intake stalls
  task automatic test_stall_pressure();
    sink_hold = 150;
    for (int i = 0; i < 20; i++) begin
      send_char(rand_digit(), 1'b0);
      send_char(";", 1'b0);
    end
    wait_results_drained();
  endtask

  task automatic test_random_idle();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    send_random_mix(RandomChars / 2);
    wait_results_drained();
    send_random_mix(RandomChars / 2);
  endtask

  task automatic test_random_quiet();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_random_mix(QuietChars);
  endtask

  initial begin
    clear_scan();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_special_cases();
    wait_results_drained();
    test_long_literals();
    test_stall_pressure();
    test_random_idle();
    test_random_quiet();
    wait_results_drained();
    if (err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[files.f]
src/dls_pkg.sv
src/dls_in_stage.sv
src/dls_scan.sv
src/dls_out_stage.sv
src/decimal_literal_scanner.sv
sim/tb.sv
